FILE: hw/rtl/itoa_pkg.sv
// Package for the integer to ASCII radix converter.
// Holds sizes, microcode word layout, the control program and the digit encoder.
// No dependencies; used by the top level and the checker.
`default_nettype none

package itoa_pkg;

	// Sizes of the value path and the digit store.
	localparam int VALUE_BITS   = 32;
	localparam int MAX_DIGITS   = 32;
	localparam int RADIX_BITS   = 6;
	localparam int CHAR_BITS    = 8;
	localparam int ADDR_BITS    = $clog2(MAX_DIGITS);
	localparam int CNT_BITS     = $clog2(MAX_DIGITS + 1);
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);
	localparam int STEP_BITS    = 3;

	// Radix limits and the radix reset value.
	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
	localparam logic [RADIX_BITS-1:0] RADIX_DEC   = RADIX_BITS'(10);
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_DEC;

	// ASCII codes.
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] ASCII_A     = 8'h61;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2d;
	localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] ASCII_Z     = 8'h7a;

	typedef logic [STEP_BITS-1:0] step_t;
	typedef logic [1:0]           cond_t;

	// Branch conditions.
	localparam cond_t C_ALWAYS   = 2'd0;
	localparam cond_t C_BIT_DONE = 2'd1;
	localparam cond_t C_MORE     = 2'd2;
	localparam cond_t C_PTR_ZERO = 2'd3;

	// Program steps.
	localparam step_t S_IDLE  = 3'd0;
	localparam step_t S_DIV   = 3'd1;
	localparam step_t S_STORE = 3'd2;
	localparam step_t S_SIGN  = 3'd3;
	localparam step_t S_RD    = 3'd4;
	localparam step_t S_EMIT  = 3'd5;
	localparam step_t S_SPARE6 = 3'd6;
	localparam step_t S_SPARE7 = 3'd7;

	// One control word per program step.
	typedef struct packed {
		logic  in_rdy;
		logic  load;
		logic  div;
		logic  store;
		logic  sign;
		logic  rd;
		logic  emit;
		logic  wait_in;
		logic  wait_out;
		cond_t cond;
		step_t t_true;
		step_t t_false;
	} ctl_t;

	localparam ctl_t UCODE [2**STEP_BITS] = '{
		// S_IDLE: wait for a word, load the magnitude.
		'{in_rdy: 1'b1, load: 1'b1, div: 1'b0, store: 1'b0, sign: 1'b0, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b1, wait_out: 1'b0, cond: C_ALWAYS,
		  t_true: S_DIV, t_false: S_DIV},
		// S_DIV: one quotient bit per cycle.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b1, store: 1'b0, sign: 1'b0, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b0, cond: C_BIT_DONE,
		  t_true: S_STORE, t_false: S_DIV},
		// S_STORE: keep the remainder as the next digit.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b1, sign: 1'b0, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b0, cond: C_MORE,
		  t_true: S_DIV, t_false: S_SIGN},
		// S_SIGN: send the minus sign if needed, point at the top digit.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b1, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b1, cond: C_ALWAYS,
		  t_true: S_RD, t_false: S_RD},
		// S_RD: read one digit from the store.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b0, rd: 1'b1,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS,
		  t_true: S_EMIT, t_false: S_EMIT},
		// S_EMIT: send the digit, finish after the least significant one.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b0, rd: 1'b0,
		  emit: 1'b1, wait_in: 1'b0, wait_out: 1'b1, cond: C_PTR_ZERO,
		  t_true: S_IDLE, t_false: S_RD},
		// Unused steps return to idle.
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b0, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS,
		  t_true: S_IDLE, t_false: S_IDLE},
		'{in_rdy: 1'b0, load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b0, rd: 1'b0,
		  emit: 1'b0, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS,
		  t_true: S_IDLE, t_false: S_IDLE}
	};

	// Digit value to its ASCII character: 0..9 as digits, 10..35 as lower-case letters.
	function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
		logic [CHAR_BITS-1:0] d8;
		d8 = CHAR_BITS'(d);
		if (d8 > CHAR_BITS'(9)) begin
			return ASCII_A + d8 - CHAR_BITS'(10);
		end
		return ASCII_ZERO + d8;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/integer_to_ascii_radix.sv
// Top level of the integer to ASCII radix converter.
// Depends on itoa_pkg and itoa_ram.
//
// Each accepted 32-bit signed value comes out as a stream of ASCII words in
// the base held in the radix register (values below 2 act as 2, above 36 as
// 36), most significant digit first, with last set on the final word. Digits
// above nine are lower-case letters, zero gives a single '0', and a leading
// '-' appears only for a negative value in base ten; other bases convert the
// raw 32-bit pattern as unsigned. The bit-serial divider produces one
// quotient bit per cycle and then stores each remainder as a digit;
// during output the digits are read back through the registered read
// port of the digit RAM.
// One item is converted at a time; the radix register may be written only
// while the block is idle.
`default_nettype none

module integer_to_ascii_radix (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_wr_en,
	input  wire logic        [itoa_pkg::RADIX_BITS-1:0]   cfg_wr_data,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic signed [itoa_pkg::VALUE_BITS-1:0]   value,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic             [itoa_pkg::CHAR_BITS-1:0]    character,
	output logic                                          last
);

	import itoa_pkg::*;

	step_t                   pc_q;
	ctl_t                    ctl;
	logic [RADIX_BITS-1:0]   radix_q;
	logic [RADIX_BITS-1:0]   base_eff;
	logic [RADIX_BITS-1:0]   base_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [RADIX_BITS-1:0]   rem_q;
	logic [DIV_CNT_BITS-1:0] bit_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [ADDR_BITS-1:0]    ptr_q;
	logic                    minus_q;
	logic                    out_valid_q;
	logic [CHAR_BITS-1:0]    char_q;
	logic                    last_q;
	logic [RADIX_BITS:0]     trial;
	logic                    geq;
	logic                    out_free;
	logic                    hold;
	logic                    cond_ok;
	logic                    do_load;
	logic                    do_sign;
	logic                    do_emit;
	logic                    load_neg;
	logic [RADIX_BITS-1:0]   rd_digit;

	// Control word for the current step.
	assign ctl = UCODE[pc_q];

	assign out_free = !out_valid_q || out_ready;
	assign hold     = (ctl.wait_in && !in_valid) || (ctl.wait_out && !out_free);
	assign do_load  = ctl.load && in_valid;
	assign do_sign  = ctl.sign && minus_q && out_free;
	assign do_emit  = ctl.emit && out_free;

	// Branch condition selected by the control word.
	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:   cond_ok = 1'b1;
			C_BIT_DONE: cond_ok = (bit_q == DIV_CNT_BITS'(VALUE_BITS - 1));
			C_MORE:     cond_ok = (mag_q != '0) && (cnt_q < CNT_BITS'(MAX_DIGITS - 1));
			C_PTR_ZERO: cond_ok = (ptr_q == '0);
			default:    cond_ok = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (!hold) begin
			pc_q <= cond_ok ? ctl.t_true : ctl.t_false;
		end
	end

	// Radix register, saturated into the legal range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_eff = RADIX_MAX;
		end else begin
			base_eff = radix_q;
		end
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
	assign geq      = trial >= {1'b0, base_q};
	assign load_neg = value[VALUE_BITS-1] && (base_eff == RADIX_DEC);

	// Divider datapath and digit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			minus_q <= 1'b0;
		end else begin
			if (do_load) begin
				cnt_q   <= '0;
				minus_q <= load_neg;
			end else if (ctl.store) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			base_q <= base_eff;
			mag_q  <= load_neg ? (~value + 1'b1) : value;
			rem_q  <= '0;
			bit_q  <= '0;
		end else if (ctl.div) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], geq};
			rem_q <= geq ? RADIX_BITS'(trial - {1'b0, base_q}) : trial[RADIX_BITS-1:0];
			bit_q <= bit_q + 1'b1;
		end else if (ctl.store) begin
			rem_q <= '0;
			bit_q <= '0;
		end
	end

	// Read pointer walks from the most significant digit down.
	always_ff @(posedge clk) begin
		if (ctl.sign && !hold) begin
			ptr_q <= ADDR_BITS'(cnt_q - 1'b1);
		end else if (do_emit && (ptr_q != '0)) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	// Digit store.
	itoa_ram #(
		.WIDTH(RADIX_BITS),
		.DEPTH(MAX_DIGITS)
	) u_digits (
		.clk    (clk),
		.wr_en  (ctl.store),
		.wr_addr(cnt_q[ADDR_BITS-1:0]),
		.wr_data(rem_q),
		.rd_en  (ctl.rd),
		.rd_addr(ptr_q),
		.rd_data(rd_digit)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_sign || do_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (do_emit) begin
			char_q <= digit_to_ascii(rd_digit);
			last_q <= (ptr_q == '0);
		end
	end

	assign in_ready  = ctl.in_rdy;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/itoa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module itoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/itoa_checker.sv
// Port-level checker for the integer to ASCII radix converter, with its bind.
// Depends on itoa_pkg and the integer_to_ascii_radix port list.
`default_nettype none

module itoa_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_ready,
	input  wire logic                                   out_valid,
	input  wire logic                                   out_ready,
	input  wire logic [itoa_pkg::CHAR_BITS-1:0]         character,
	input  wire logic                                   last
);

	import itoa_pkg::*;

	// A stalled output word holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("output word changed while stalled");

	// Every word is a digit, a lower-case letter or a minus sign.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character >= ASCII_ZERO && character <= ASCII_NINE) ||
			(character >= ASCII_A && character <= ASCII_Z) || (character == ASCII_MINUS))
		else $error("output word is not a valid character");

	// A new value is taken only once the previous text is down to its last word.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("input ready while text still in progress");

	// After a value is taken the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting a value");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

`default_nettype wire
